// File: design/busdec_pkg.sv
// shared types, codes and region table for the bus address decoder
// no dependencies; imported by every busdec module
package busdec_pkg;

  localparam int AddrW = 32;
  localparam int DataW = 32;
  localparam int SizeW = 2;
  localparam int DevW  = 3;
  localparam int OffW  = 23;
  localparam int StW   = 3;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DataW-1:0] data_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [DevW-1:0]  dev_t;
  typedef logic [OffW-1:0]  off_t;
  typedef logic [StW-1:0]   st_t;

  // access sizes
  localparam size_t SZ_BYTE = 2'd0;
  localparam size_t SZ_HALF = 2'd1;
  localparam size_t SZ_WORD = 2'd2;

  // target devices
  localparam dev_t DEV_NONE   = 3'd0;
  localparam dev_t DEV_BIOS   = 3'd1;
  localparam dev_t DEV_RAM    = 3'd2;
  localparam dev_t DEV_CDROM  = 3'd3;
  localparam dev_t DEV_DMA    = 3'd4;
  localparam dev_t DEV_GPU    = 3'd5;
  localparam dev_t DEV_TIMERS = 3'd6;

  // access status
  localparam st_t ST_ROUTED  = 3'd0;
  localparam st_t ST_IGNORED = 3'd1;
  localparam st_t ST_FIXED   = 3'd2;
  localparam st_t ST_UNALIGN = 3'd3;
  localparam st_t ST_UNMAP   = 3'd4;
  localparam st_t ST_BADBASE = 3'd5;

  localparam data_t EXP1_BASE_EXPECTED = 32'h1F00_0000;
  localparam data_t EXP2_BASE_EXPECTED = 32'h1F80_2000;

  localparam data_t VAL_EXP1_BYTE = 32'h0000_00FF;
  localparam data_t VAL_UNMAP_B   = 32'h0000_00DE;
  localparam data_t VAL_UNMAP_H   = 32'h0000_DEAD;
  localparam data_t VAL_UNMAP_W   = 32'hDEAD_BEEF;

  // region indexes
  localparam int RG_RAM      = 0;
  localparam int RG_EXP1     = 1;
  localparam int RG_MEMCTL   = 2;
  localparam int RG_RAMSIZE  = 3;
  localparam int RG_IRQ      = 4;
  localparam int RG_DMA      = 5;
  localparam int RG_TIMERS   = 6;
  localparam int RG_CDROM    = 7;
  localparam int RG_GPU      = 8;
  localparam int RG_SPU      = 9;
  localparam int RG_EXP2     = 10;
  localparam int RG_BIOS     = 11;
  localparam int RG_CACHECTL = 12;
  localparam int NRegion     = 13;

  localparam addr_t RG_BASE [NRegion] = '{
    32'h0000_0000, 32'h1F00_0000, 32'h1F80_1000, 32'h1F80_1060,
    32'h1F80_1070, 32'h1F80_1080, 32'h1F80_1100, 32'h1F80_1800,
    32'h1F80_1810, 32'h1F80_1C00, 32'h1F80_2000, 32'h1FC0_0000,
    32'hFFFE_0130
  };

  localparam addr_t RG_SIZE [NRegion] = '{
    32'h0020_0000, 32'h0080_0000, 32'd36, 32'd4,
    32'd8, 32'd128, 32'd48, 32'd4,
    32'd8, 32'd640, 32'd128, 32'h0008_0000,
    32'd4
  };

  localparam off_t MEMCTL_EXP1_OFF = 23'd0;
  localparam off_t MEMCTL_EXP2_OFF = 23'd4;

  // segment mask picked by the top three address bits
  function automatic addr_t seg_mask(input logic [2:0] seg);
    addr_t m;
    case (seg)
      3'd4:    m = 32'h7FFF_FFFF;
      3'd5:    m = 32'h1FFF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  typedef struct packed {
    addr_t phys;
    size_t size;
    logic  store;
    logic  bad_size;
    logic  unalign;
    logic  data_exp1;
    logic  data_exp2;
  } s1_t;

  typedef struct packed {
    logic [NRegion-1:0] hit;
    size_t size;
    logic  store;
    logic  bad_size;
    logic  unalign;
    logic  data_exp1;
    logic  data_exp2;
  } s2_t;

  typedef struct packed {
    dev_t  dev;
    off_t  off;
    st_t   st;
    data_t val;
  } res_t;

endpackage

// File: design/busdec_seg.sv
// stage 1: segment folding, size and alignment checks, data compares
// depends on busdec_pkg
module busdec_seg import busdec_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  addr_t addr,
  input  size_t size,
  input  logic  store,
  input  data_t wdata,
  output logic  dn_valid,
  input  logic  dn_ready,
  output s1_t   dn_data
);

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.phys      = addr & seg_mask(addr[AddrW-1 -: 3]);
    data_nxt.size      = size;
    data_nxt.store     = store;
    data_nxt.bad_size  = (size > SZ_WORD);
    data_nxt.unalign   = ((size == SZ_HALF) && addr[0]) ||
                         ((size == SZ_WORD) && (addr[1:0] != 2'b00));
    data_nxt.data_exp1 = (wdata == EXP1_BASE_EXPECTED);
    data_nxt.data_exp2 = (wdata == EXP2_BASE_EXPECTED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: design/busdec_range.sv
// stage 2: range compares of the physical address against every region
// depends on busdec_pkg
module busdec_range import busdec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s1_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output s2_t  dn_data,
  output off_t dn_off [NRegion]
);

  logic valid_r;
  s2_t  data_r;
  s2_t  data_nxt;
  off_t off_r   [NRegion];
  off_t off_nxt [NRegion];
  addr_t diff   [NRegion];

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign dn_off   = off_r;

  always_comb begin
    for (int i = 0; i < NRegion; i++) begin
      diff[i]         = up_data.phys - RG_BASE[i];
      data_nxt.hit[i] = (up_data.phys >= RG_BASE[i]) && (diff[i] < RG_SIZE[i]);
      off_nxt[i]      = diff[i][OffW-1:0];
    end
    data_nxt.size      = up_data.size;
    data_nxt.store     = up_data.store;
    data_nxt.bad_size  = up_data.bad_size;
    data_nxt.unalign   = up_data.unalign;
    data_nxt.data_exp1 = up_data.data_exp1;
    data_nxt.data_exp2 = up_data.data_exp2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule

// File: design/busdec_sel.sv
// stage 3: priority pick per size and direction, result register
// depends on busdec_pkg
module busdec_sel import busdec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s2_t  up_data,
  input  off_t up_off [NRegion],
  output logic dn_valid,
  input  logic dn_ready,
  output res_t dn_data
);

  logic valid_r;
  res_t data_r;
  res_t res;
  logic [NRegion-1:0] h;
  logic mc_bad;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign h        = up_data.hit;

  assign mc_bad = ((up_off[RG_MEMCTL] == MEMCTL_EXP1_OFF) && !up_data.data_exp1) ||
                  ((up_off[RG_MEMCTL] == MEMCTL_EXP2_OFF) && !up_data.data_exp2);

  always_comb begin
    res.dev = DEV_NONE;
    res.off = '0;
    res.st  = ST_UNMAP;
    res.val = '0;
    if (up_data.bad_size) begin
      res.st = ST_UNMAP;
    end else if (up_data.unalign) begin
      res.st = ST_UNALIGN;
    end else if (!up_data.store) begin
      case (up_data.size)
        SZ_BYTE: begin
          res.val = VAL_UNMAP_B;
          if (h[RG_BIOS]) begin
            res = '{DEV_BIOS, up_off[RG_BIOS], ST_ROUTED, '0};
          end else if (h[RG_RAM]) begin
            res = '{DEV_RAM, up_off[RG_RAM], ST_ROUTED, '0};
          end else if (h[RG_CDROM]) begin
            res = '{DEV_CDROM, up_off[RG_CDROM], ST_ROUTED, '0};
          end else if (h[RG_EXP1]) begin
            res = '{DEV_NONE, up_off[RG_EXP1], ST_FIXED, VAL_EXP1_BYTE};
          end
        end
        SZ_HALF: begin
          res.val = VAL_UNMAP_H;
          if (h[RG_RAM]) begin
            res = '{DEV_RAM, up_off[RG_RAM], ST_ROUTED, '0};
          end else if (h[RG_SPU]) begin
            res = '{DEV_NONE, up_off[RG_SPU], ST_FIXED, '0};
          end else if (h[RG_IRQ]) begin
            res = '{DEV_NONE, up_off[RG_IRQ], ST_FIXED, '0};
          end
        end
        default: begin
          res.val = VAL_UNMAP_W;
          if (h[RG_BIOS]) begin
            res = '{DEV_BIOS, up_off[RG_BIOS], ST_ROUTED, '0};
          end else if (h[RG_RAM]) begin
            res = '{DEV_RAM, up_off[RG_RAM], ST_ROUTED, '0};
          end else if (h[RG_DMA]) begin
            res = '{DEV_DMA, up_off[RG_DMA], ST_ROUTED, '0};
          end else if (h[RG_GPU]) begin
            res = '{DEV_GPU, up_off[RG_GPU], ST_ROUTED, '0};
          end else if (h[RG_IRQ]) begin
            res = '{DEV_NONE, up_off[RG_IRQ], ST_FIXED, '0};
          end else if (h[RG_TIMERS]) begin
            res = '{DEV_TIMERS, up_off[RG_TIMERS], ST_ROUTED, '0};
          end
        end
      endcase
    end else begin
      case (up_data.size)
        SZ_BYTE: begin
          if (h[RG_RAM]) begin
            res = '{DEV_RAM, up_off[RG_RAM], ST_ROUTED, '0};
          end else if (h[RG_CDROM]) begin
            res = '{DEV_CDROM, up_off[RG_CDROM], ST_ROUTED, '0};
          end else if (h[RG_EXP2]) begin
            res = '{DEV_NONE, up_off[RG_EXP2], ST_IGNORED, '0};
          end
        end
        SZ_HALF: begin
          if (h[RG_RAM]) begin
            res = '{DEV_RAM, up_off[RG_RAM], ST_ROUTED, '0};
          end else if (h[RG_SPU]) begin
            res = '{DEV_NONE, up_off[RG_SPU], ST_IGNORED, '0};
          end else if (h[RG_IRQ]) begin
            res = '{DEV_NONE, up_off[RG_IRQ], ST_IGNORED, '0};
          end else if (h[RG_TIMERS]) begin
            res = '{DEV_TIMERS, up_off[RG_TIMERS], ST_ROUTED, '0};
          end
        end
        default: begin
          if (h[RG_RAM]) begin
            res = '{DEV_RAM, up_off[RG_RAM], ST_ROUTED, '0};
          end else if (h[RG_DMA]) begin
            res = '{DEV_DMA, up_off[RG_DMA], ST_ROUTED, '0};
          end else if (h[RG_GPU]) begin
            res = '{DEV_GPU, up_off[RG_GPU], ST_ROUTED, '0};
          end else if (h[RG_IRQ]) begin
            res = '{DEV_NONE, up_off[RG_IRQ], ST_IGNORED, '0};
          end else if (h[RG_TIMERS]) begin
            res = '{DEV_TIMERS, up_off[RG_TIMERS], ST_ROUTED, '0};
          end else if (h[RG_CACHECTL]) begin
            res = '{DEV_NONE, up_off[RG_CACHECTL], ST_IGNORED, '0};
          end else if (h[RG_MEMCTL]) begin
            res = '{DEV_NONE, up_off[RG_MEMCTL],
                    (mc_bad ? ST_BADBASE : ST_IGNORED), '0};
          end else if (h[RG_RAMSIZE]) begin
            res = '{DEV_NONE, up_off[RG_RAMSIZE], ST_IGNORED, '0};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= res;
    end
  end

endmodule

// File: design/bus_address_decoder_core.sv
// path: an accepted input beat is registered by seg, range and sel in turn, then leaves as its result beat
// throughput: one beat per cycle; each of the three stages holds one beat
//   and advances whenever the stage below it is empty or moving
// reset: synchronous active-low rst_n clears all stage valid bits
// top level of the bus address decoder; depends on busdec_pkg,
//   busdec_seg, busdec_range and busdec_sel
module bus_address_decoder_core import busdec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] bus_address, [33:32] access_size, [65:34] write_data, [71:66] zero
  input  logic [71:0] in_tdata,
  // [0] command (0 load, 1 store)
  input  logic        in_tuser,
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] target_device, [25:3] device_offset, [28:26] access_status,
  // [60:29] fixed_read_value, [63:61] zero
  output logic [63:0] out_tdata
);

  // stage 1 -> stage 2
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;

  // stage 2 -> stage 3
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;
  off_t s2_off [NRegion];

  res_t res;

  // segment fold and early checks
  busdec_seg u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .addr     (in_tdata[31:0]),
    .size     (in_tdata[33:32]),
    .store    (in_tuser),
    .wdata    (in_tdata[65:34]),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // per-region hit flags and offsets
  busdec_range u_range (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data),
    .dn_off   (s2_off)
  );

  // priority pick, doubles as the output register
  busdec_sel u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .up_off   (s2_off),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  assign out_tdata = {3'b000, res.val, res.st, res.off, res.dev};

endmodule

// File: tb/tb.sv
// testbench for bus_address_decoder_core: drives random and directed cpu accesses
// through the input stream and checks every result beat against a built-in decoder
// depends on busdec_pkg and the bus_address_decoder_core rtl
module tb;
  import busdec_pkg::*;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;
  localparam int   CYCLE_LIMIT = 500000;
  localparam int   N_ACCESS    = 1800;

  // physical memory map, indexed by the span codes below
  localparam int SP_RAM      = 0;
  localparam int SP_EXP1     = 1;
  localparam int SP_MEMCTL   = 2;
  localparam int SP_RAMSIZE  = 3;
  localparam int SP_IRQ      = 4;
  localparam int SP_DMA      = 5;
  localparam int SP_TIMERS   = 6;
  localparam int SP_CDROM    = 7;
  localparam int SP_GPU      = 8;
  localparam int SP_SPU      = 9;
  localparam int SP_EXP2     = 10;
  localparam int SP_BIOS     = 11;
  localparam int SP_CACHECTL = 12;
  localparam int N_SPAN      = 13;

  localparam addr_t SPAN_BASE [N_SPAN] = '{
    32'h0000_0000, 32'h1F00_0000, 32'h1F80_1000, 32'h1F80_1060,
    32'h1F80_1070, 32'h1F80_1080, 32'h1F80_1100, 32'h1F80_1800,
    32'h1F80_1810, 32'h1F80_1C00, 32'h1F80_2000, 32'h1FC0_0000,
    32'hFFFE_0130
  };
  localparam addr_t SPAN_LEN [N_SPAN] = '{
    32'h0020_0000, 32'h0080_0000, 32'd36, 32'd4,
    32'd8, 32'd128, 32'd48, 32'd4,
    32'd8, 32'd640, 32'd128, 32'h0008_0000,
    32'd4
  };

  typedef struct packed {
    dev_t  dev;
    off_t  off;
    st_t   st;
    data_t val;
  } decode_res_t;

  // holds the decodes still owed by the block, in order
  class access_scoreboard;
    decode_res_t owed_q[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function bit span_hit(addr_t pa, int sp, output off_t o);
      addr_t d;
      d = pa - SPAN_BASE[sp];
      o = d[OffW-1:0];
      return (pa >= SPAN_BASE[sp]) && (d < SPAN_LEN[sp]);
    endfunction

    function decode_res_t mk(dev_t dev, off_t off, st_t st, data_t val);
      decode_res_t r;
      r.dev = dev;
      r.off = off;
      r.st  = st;
      r.val = val;
      return r;
    endfunction

    function decode_res_t decode_access(addr_t va, size_t sz, logic wr, data_t wd);
      addr_t pa;
      off_t  o;
      bit    bad;
      // kseg0 drops bit 31, kseg1 drops the three segment bits
      pa = va;
      if (va[31:29] == 3'b100) pa[31] = 1'b0;
      else if (va[31:29] == 3'b101) pa[31:29] = 3'b000;
      if (sz > SZ_WORD) return mk(DEV_NONE, '0, ST_UNMAP, '0);
      if ((sz == SZ_HALF && va[0]) || (sz == SZ_WORD && va[1:0] != 2'b00))
        return mk(DEV_NONE, '0, ST_UNALIGN, '0);
      if (wr == CMD_LOAD) begin
        if (sz == SZ_BYTE) begin
          if (span_hit(pa, SP_BIOS, o))  return mk(DEV_BIOS, o, ST_ROUTED, '0);
          if (span_hit(pa, SP_RAM, o))   return mk(DEV_RAM, o, ST_ROUTED, '0);
          if (span_hit(pa, SP_CDROM, o)) return mk(DEV_CDROM, o, ST_ROUTED, '0);
          if (span_hit(pa, SP_EXP1, o))  return mk(DEV_NONE, o, ST_FIXED, VAL_EXP1_BYTE);
          return mk(DEV_NONE, '0, ST_UNMAP, VAL_UNMAP_B);
        end
        if (sz == SZ_HALF) begin
          if (span_hit(pa, SP_RAM, o)) return mk(DEV_RAM, o, ST_ROUTED, '0);
          if (span_hit(pa, SP_SPU, o)) return mk(DEV_NONE, o, ST_FIXED, '0);
          if (span_hit(pa, SP_IRQ, o)) return mk(DEV_NONE, o, ST_FIXED, '0);
          return mk(DEV_NONE, '0, ST_UNMAP, VAL_UNMAP_H);
        end
        if (span_hit(pa, SP_BIOS, o))   return mk(DEV_BIOS, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_RAM, o))    return mk(DEV_RAM, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_DMA, o))    return mk(DEV_DMA, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_GPU, o))    return mk(DEV_GPU, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_IRQ, o))    return mk(DEV_NONE, o, ST_FIXED, '0);
        if (span_hit(pa, SP_TIMERS, o)) return mk(DEV_TIMERS, o, ST_ROUTED, '0);
        return mk(DEV_NONE, '0, ST_UNMAP, VAL_UNMAP_W);
      end
      if (sz == SZ_BYTE) begin
        if (span_hit(pa, SP_RAM, o))   return mk(DEV_RAM, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_CDROM, o)) return mk(DEV_CDROM, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_EXP2, o))  return mk(DEV_NONE, o, ST_IGNORED, '0);
      end else if (sz == SZ_HALF) begin
        if (span_hit(pa, SP_RAM, o))    return mk(DEV_RAM, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_SPU, o))    return mk(DEV_NONE, o, ST_IGNORED, '0);
        if (span_hit(pa, SP_IRQ, o))    return mk(DEV_NONE, o, ST_IGNORED, '0);
        if (span_hit(pa, SP_TIMERS, o)) return mk(DEV_TIMERS, o, ST_ROUTED, '0);
      end else begin
        if (span_hit(pa, SP_RAM, o))      return mk(DEV_RAM, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_DMA, o))      return mk(DEV_DMA, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_GPU, o))      return mk(DEV_GPU, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_IRQ, o))      return mk(DEV_NONE, o, ST_IGNORED, '0);
        if (span_hit(pa, SP_TIMERS, o))   return mk(DEV_TIMERS, o, ST_ROUTED, '0);
        if (span_hit(pa, SP_CACHECTL, o)) return mk(DEV_NONE, o, ST_IGNORED, '0);
        if (span_hit(pa, SP_MEMCTL, o)) begin
          // expansion base words must hold their fixed addresses
          bad = (o == MEMCTL_EXP1_OFF && wd != EXP1_BASE_EXPECTED) ||
                (o == MEMCTL_EXP2_OFF && wd != EXP2_BASE_EXPECTED);
          return mk(DEV_NONE, o, bad ? ST_BADBASE : ST_IGNORED, '0);
        end
        if (span_hit(pa, SP_RAMSIZE, o)) return mk(DEV_NONE, o, ST_IGNORED, '0);
      end
      return mk(DEV_NONE, '0, ST_UNMAP, '0);
    endfunction

    function void note_access(addr_t va, size_t sz, logic wr, data_t wd);
      owed_q.push_back(decode_access(va, sz, wr, wd));
    endfunction

    function void check_result(logic [63:0] beat);
      decode_res_t got, want;
      got.dev = beat[2:0];
      got.off = beat[25:3];
      got.st  = beat[28:26];
      got.val = beat[60:29];
      if (owed_q.size() == 0) begin
        if (mismatches < 10)
          $display("result beat with no access pending: dev %0d off %h st %0d val %h",
                   got.dev, got.off, got.st, got.val);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        if (mismatches < 10)
          $display("mismatch: exp dev %0d off %h st %0d val %h, got dev %0d off %h st %0d val %h",
                   want.dev, want.off, want.st, want.val,
                   got.dev, got.off, got.st, got.val);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  int          cycles = 0;

  access_scoreboard sb;

  bus_address_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result monitor: values read here are the ones the edge samples
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_access(addr_t va, size_t sz, logic wr, data_t wd);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, wd, sz, va};
    in_tuser  <= wr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_access(va, sz, wr, wd);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the input off until every owed result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic directed(addr_t va, size_t sz, logic wr, data_t wd);
    send_access(va, sz, wr, wd);
    idle_sender(gap_len());
  endtask

  // aims most accesses at a mapped span, folded through a random segment
  task automatic pick_access(output addr_t va, output size_t sz, output logic wr,
                             output data_t wd);
    int    sp, pick;
    addr_t off, pa;
    logic [4:0] bitn;
    wr   = 1'($urandom_range(0, 1));
    sz   = ($urandom_range(0, 99) < 5) ? 2'd3 : size_t'($urandom_range(0, 2));
    wd   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      va = $urandom;
      return;
    end
    sp  = $urandom_range(0, N_SPAN - 1);
    off = $urandom % SPAN_LEN[sp];
    if ($urandom_range(0, 99) < 85) begin
      if (sz == SZ_HALF) off[0] = 1'b0;
      else if (sz == SZ_WORD) off[1:0] = 2'b00;
    end
    // just outside either end of the span
    if (pick < 30)
      off = $urandom_range(0, 1) ? SPAN_LEN[sp] + $urandom_range(0, 3)
                                 : addr_t'(0) - $urandom_range(1, 4);
    // expansion base words with the right or a near-miss value
    if (sp == SP_MEMCTL && $urandom_range(0, 1)) begin
      wr  = CMD_STORE;
      sz  = SZ_WORD;
      off = $urandom_range(0, 1) ? 32'd4 : 32'd0;
      wd  = (off == 0) ? EXP1_BASE_EXPECTED : EXP2_BASE_EXPECTED;
      if ($urandom_range(0, 3) == 0) begin
        bitn     = 5'($urandom_range(0, 31));
        wd[bitn] = ~wd[bitn];
      end
    end
    pa = SPAN_BASE[sp] + off;
    va = pa;
    if (pa[31:29] == 3'b000) begin
      case ($urandom_range(0, 2))
        1: va[31] = 1'b1;
        2: va[31:29] = 3'b101;
        default: ;
      endcase
    end
  endtask

  // result side: ready runs broken by stalls, with some long stall-free stretches
  initial begin
    int run;
    int g;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    addr_t va;
    size_t sz;
    logic  wr;
    data_t wd;
    bit    burst;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_LOAD;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every size and direction, stubs, faults and the base checks
    directed(32'hBFC0_0000, SZ_BYTE, CMD_LOAD,  32'h0000_0000);
    directed(32'h801F_FFFF, SZ_BYTE, CMD_LOAD,  32'hFFFF_FFFF);
    directed(32'h1F80_1803, SZ_BYTE, CMD_LOAD,  32'h0000_0000);
    directed(32'h1F7F_FFFF, SZ_BYTE, CMD_LOAD,  32'h0000_0000);
    directed(32'hFFFF_FFFF, SZ_BYTE, CMD_LOAD,  32'h0000_0000);
    directed(32'hBF80_1E7E, SZ_HALF, CMD_LOAD,  32'h0000_0000);
    directed(32'h1F80_1076, SZ_HALF, CMD_LOAD,  32'h0000_0000);
    directed(32'h0020_0000, SZ_HALF, CMD_LOAD,  32'h0000_0000);
    directed(32'h0000_0001, SZ_HALF, CMD_LOAD,  32'h0000_0000);
    directed(32'h9FC7_FFFC, SZ_WORD, CMD_LOAD,  32'h0000_0000);
    directed(32'h1F80_10FC, SZ_WORD, CMD_LOAD,  32'h0000_0000);
    directed(32'h1F80_1814, SZ_WORD, CMD_LOAD,  32'h0000_0000);
    directed(32'h1F80_1070, SZ_WORD, CMD_LOAD,  32'h0000_0000);
    directed(32'h1F80_112C, SZ_WORD, CMD_LOAD,  32'h0000_0000);
    directed(32'h1F80_1130, SZ_WORD, CMD_LOAD,  32'h0000_0000);
    directed(32'h0000_0002, SZ_WORD, CMD_STORE, 32'h0000_0000);
    directed(32'h0000_0000, 2'd3,    CMD_LOAD,  32'hFFFF_FFFF);
    directed(32'h1F80_207F, SZ_BYTE, CMD_STORE, 32'hFFFF_FFFF);
    directed(32'hBFC0_0000, SZ_BYTE, CMD_STORE, 32'h0000_00FF);
    directed(32'h1F80_1100, SZ_HALF, CMD_STORE, 32'h0000_FFFF);
    directed(32'h1F80_1C00, SZ_HALF, CMD_STORE, 32'h0000_1234);
    directed(32'hFFFE_0130, SZ_WORD, CMD_STORE, 32'hFFFF_FFFF);
    directed(32'h1F80_1000, SZ_WORD, CMD_STORE, EXP1_BASE_EXPECTED);
    directed(32'h1F80_1000, SZ_WORD, CMD_STORE, 32'h0000_0000);
    directed(32'hBF80_1004, SZ_WORD, CMD_STORE, EXP2_BASE_EXPECTED);
    directed(32'h1F80_1004, SZ_WORD, CMD_STORE, EXP1_BASE_EXPECTED);
    directed(32'h1F80_1008, SZ_WORD, CMD_STORE, 32'hDEAD_BEEF);
    directed(32'h1F80_1060, SZ_WORD, CMD_STORE, 32'h0000_0000);
    drain();

    // random accesses; every fourth block of 150 runs back to back
    for (int i = 0; i < N_ACCESS; i++) begin
      burst = ((i / 150) % 4) == 3;
      pick_access(va, sz, wr, wd);
      send_access(va, sz, wr, wd);
      if (i == N_ACCESS / 2) drain();
      else if (!burst) idle_sender(gap_len());
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
